// ===== hdl/cfa_pkg.sv =====
// Shared types and constants for the closest-facet altitude block.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package cfa_pkg;

  // Field widths of one beat
  localparam int POS_W = 32;  // Q15.16 coordinate
  localparam int NRM_W = 18;  // Q1.16 normal component
  localparam int IDX_W = 10;  // facet index on the ports
  localparam int ALT_W = 34;  // Q18.16 altitude
  localparam int CNT_W = 11;  // facet_count register

  // Internal arithmetic widths
  localparam int DIF_W = POS_W + 1;      // point minus center
  localparam int SQ_W  = 2 * POS_W;      // one squared difference
  localparam int PRD_W = 2 * DIF_W;      // shared lane multiplier result
  localparam int CEN_W = 3 * POS_W;      // packed center entry
  localparam int NEN_W = 3 * NRM_W;      // packed normal entry
  localparam int RND_W = PRD_W - 16;     // magnitude after the rounding shift

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_we;      // write the input beat into the facet tables
    logic query_start;  // latch the query point, clear the running best
    logic scan_rd;      // read entry at scan address for distance
    logic fetch_rd;     // read the best entry for the altitude
    logic emit_empty;   // present an empty-table result
  } dp_ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_busy;    // distance pipeline still holds entries
    logic result_done;  // altitude result is being registered
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/closest_facet_altitude.sv =====
// Top level of the closest-facet altitude block.
// Instantiates cfa_ctrl and cfa_dpath; types and constants from cfa_pkg.
//
// Usage:
//   Input channel: a beat is taken at a rising edge with start high and busy
//   low. in_command selects a load (write facet in_entry_index with center
//   in_pos_* and normal in_norm_*) or a query (point in in_pos_*).
//   A load gives no result; busy stays low.
//   A query scans entries 0 .. N-1 with N = min(facet_count, MAX_FACETS),
//   one table read per cycle from the facet RAMs, through a five-stage
//   distance pipeline, then re-reads the nearest entry for the altitude.
//   Busy falls in the same cycle as out_strobe rises for the result, so a
//   new query is taken only after the last one has finished.
//   An empty table gives a result in the next cycle with out_empty_error set.
//   Result channel: out_strobe is high for one cycle per result; the
//   receiver cannot stall, so results are never held back.
//   Configuration: cfg_data is written to facet_count on cfg_valid; cfg_ready
//   is always high. Write it only while busy is low.
//   Reset: facet_count clears to zero and the sequencer returns to idle; the
//   facet tables are not cleared and need no clearing pass.
`default_nettype none

module closest_facet_altitude import cfa_pkg::*; #(
  parameter int MAX_FACETS = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_command,
  input  wire logic        [IDX_W-1:0] in_entry_index,
  input  wire logic signed [POS_W-1:0] in_pos_x,
  input  wire logic signed [POS_W-1:0] in_pos_y,
  input  wire logic signed [POS_W-1:0] in_pos_z,
  input  wire logic signed [NRM_W-1:0] in_norm_x,
  input  wire logic signed [NRM_W-1:0] in_norm_y,
  input  wire logic signed [NRM_W-1:0] in_norm_z,
  output logic                         out_strobe,
  output logic             [IDX_W-1:0] out_closest_index,
  output logic             [ALT_W-1:0] out_altitude,
  output logic signed      [POS_W-1:0] out_center_x,
  output logic signed      [POS_W-1:0] out_center_y,
  output logic signed      [POS_W-1:0] out_center_z,
  output logic                         out_empty_error,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic        [CNT_W-1:0] cfg_data
);

  localparam int AW = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;
  localparam int CW = $clog2(MAX_FACETS + 1);

  dp_ctrl_t      ctrl;
  dp_stat_t      stat;
  logic [AW-1:0] scan_addr;

  cfa_ctrl #(
    .MAX_FACETS (MAX_FACETS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .busy       (busy),
    .cfg_ready  (cfg_ready),
    .ctrl       (ctrl),
    .scan_addr  (scan_addr)
  );

  cfa_dpath #(
    .MAX_FACETS (MAX_FACETS),
    .AW         (AW)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .scan_addr         (scan_addr),
    .in_entry_index    (in_entry_index),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_norm_x         (in_norm_x),
    .in_norm_y         (in_norm_y),
    .in_norm_z         (in_norm_z),
    .stat              (stat),
    .out_strobe        (out_strobe),
    .out_closest_index (out_closest_index),
    .out_altitude      (out_altitude),
    .out_center_x      (out_center_x),
    .out_center_y      (out_center_y),
    .out_center_z      (out_center_z),
    .out_empty_error   (out_empty_error)
  );

endmodule

`default_nettype wire

// ===== hdl/cfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the facet tables.
`default_nettype none

module cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/cfa_ctrl.sv =====
// Controller: command decode, facet_count register and the scan sequencer.
// Depends on cfa_pkg; drives cfa_dpath through dp_ctrl_t / dp_stat_t.
`default_nettype none

module cfa_ctrl import cfa_pkg::*; #(
  parameter int MAX_FACETS = 1024,
  parameter int AW         = 10,
  parameter int CW         = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             in_command,
  input  wire logic             cfg_valid,
  input  wire logic [CNT_W-1:0] cfg_data,
  input  wire dp_stat_t         stat,
  output logic                  busy,
  output logic                  cfg_ready,
  output dp_ctrl_t              ctrl,
  output logic      [AW-1:0]    scan_addr
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_DOT   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;    // scan position
  logic [CW-1:0]    lim_r, lim_nxt;    // entries to scan
  logic [CNT_W-1:0] facet_count_r;
  logic [CW-1:0]    count_lim;
  logic             accept;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign scan_addr = idx_r[AW-1:0];

  // Clamp the count to the table capacity
  assign count_lim = (int'(facet_count_r) > MAX_FACETS) ? CW'(MAX_FACETS)
                                                        : CW'(facet_count_r);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      facet_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      facet_count_r <= cfg_data;
    end
  end

  // Sequencer next state and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    ctrl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LOAD) begin
            ctrl.load_we = 1'b1;
          end else begin
            ctrl.query_start = 1'b1;
            if (facet_count_r == '0) begin
              ctrl.emit_empty = 1'b1;
            end else begin
              idx_nxt   = '0;
              lim_nxt   = count_lim;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        ctrl.scan_rd = 1'b1;
        if (idx_r == lim_r - 1'b1) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait until the last distance has been compared
        if (!stat.scan_busy) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        ctrl.fetch_rd = 1'b1;
        state_nxt     = ST_DOT;
      end
      ST_DOT: begin
        if (stat.result_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      lim_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      lim_r   <= lim_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cfa_dpath.sv =====
// Datapath: facet tables, distance pipeline, best tracker and altitude unit.
// Depends on cfa_pkg and cfa_ram; commanded by cfa_ctrl.
`default_nettype none

module cfa_dpath import cfa_pkg::*; #(
  parameter int MAX_FACETS = 1024,
  parameter int AW         = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_ctrl_t                ctrl,
  input  wire logic        [AW-1:0]    scan_addr,
  input  wire logic        [IDX_W-1:0] in_entry_index,
  input  wire logic signed [POS_W-1:0] in_pos_x,
  input  wire logic signed [POS_W-1:0] in_pos_y,
  input  wire logic signed [POS_W-1:0] in_pos_z,
  input  wire logic signed [NRM_W-1:0] in_norm_x,
  input  wire logic signed [NRM_W-1:0] in_norm_y,
  input  wire logic signed [NRM_W-1:0] in_norm_z,
  output dp_stat_t                     stat,
  output logic                         out_strobe,
  output logic             [IDX_W-1:0] out_closest_index,
  output logic             [ALT_W-1:0] out_altitude,
  output logic signed      [POS_W-1:0] out_center_x,
  output logic signed      [POS_W-1:0] out_center_y,
  output logic signed      [POS_W-1:0] out_center_z,
  output logic                         out_empty_error
);

  // Facet tables
  logic             tbl_we;
  logic [AW-1:0]    tbl_waddr;
  logic [AW-1:0]    tbl_raddr;
  logic [CEN_W-1:0] cen_rd;
  logic [NEN_W-1:0] nrm_rd;

  // Query point
  logic signed [POS_W-1:0] pt_r [3];

  // Pipeline tags
  logic          s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic          s1_fch_r, s2_fch_r, s3_fch_r, s4_fch_r;
  logic [AW-1:0] s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r;

  // Pipeline payload
  logic signed [POS_W-1:0] cen_k   [3];
  logic signed [NRM_W-1:0] nrm_k   [3];
  logic signed [DIF_W-1:0] dif_nxt [3];
  logic signed [DIF_W-1:0] dif_r   [3];
  logic signed [NRM_W-1:0] nrm_r   [3];
  logic signed [DIF_W-1:0] mul_b   [3];
  logic signed [PRD_W-1:0] prd_nxt [3];
  logic signed [PRD_W-1:0] prd_r   [3];
  logic        [PRD_W-1:0] acc_r;
  logic        [CEN_W-1:0] cen_hold_r;

  // Best tracker
  logic             best_have_r;
  logic [AW-1:0]    best_idx_r;
  logic [PRD_W-1:0] best_dist_r;
  logic             take_best;

  // Altitude rounding
  logic [PRD_W-1:0] dot_mag;
  logic [PRD_W-1:0] dot_rnd;
  logic [RND_W-1:0] alt_wide;
  logic [ALT_W-1:0] alt_sat;

  // Write only entries inside the table
  assign tbl_we    = ctrl.load_we && (int'(in_entry_index) < MAX_FACETS);
  assign tbl_waddr = AW'(in_entry_index);
  assign tbl_raddr = ctrl.fetch_rd ? best_idx_r : scan_addr;

  cfa_ram #(
    .WIDTH (CEN_W),
    .DEPTH (MAX_FACETS),
    .AW    (AW)
  ) u_cen_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata ({in_pos_x, in_pos_y, in_pos_z}),
    .raddr (tbl_raddr),
    .rdata (cen_rd)
  );

  cfa_ram #(
    .WIDTH (NEN_W),
    .DEPTH (MAX_FACETS),
    .AW    (AW)
  ) u_nrm_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata ({in_norm_x, in_norm_y, in_norm_z}),
    .raddr (tbl_raddr),
    .rdata (nrm_rd)
  );

  // Latch the query point
  always_ff @(posedge clk) begin
    if (ctrl.query_start) begin
      pt_r[0] <= in_pos_x;
      pt_r[1] <= in_pos_y;
      pt_r[2] <= in_pos_z;
    end
  end

  // Advance the pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctrl.scan_rd || ctrl.fetch_rd;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_fch_r <= ctrl.fetch_rd;
    s2_fch_r <= s1_fch_r;
    s3_fch_r <= s2_fch_r;
    s4_fch_r <= s3_fch_r;
    s1_idx_r <= tbl_raddr;
    s2_idx_r <= s1_idx_r;
    s3_idx_r <= s2_idx_r;
    s4_idx_r <= s3_idx_r;
  end

  // Stage 2: unpack the entry, form point minus center
  always_comb begin
    cen_k[0] = cen_rd[3*POS_W-1:2*POS_W];
    cen_k[1] = cen_rd[2*POS_W-1:POS_W];
    cen_k[2] = cen_rd[POS_W-1:0];
    nrm_k[0] = nrm_rd[3*NRM_W-1:2*NRM_W];
    nrm_k[1] = nrm_rd[2*NRM_W-1:NRM_W];
    nrm_k[2] = nrm_rd[NRM_W-1:0];
    for (int k = 0; k < 3; k++) begin
      dif_nxt[k] = $signed({pt_r[k][POS_W-1], pt_r[k]})
                 - $signed({cen_k[k][POS_W-1], cen_k[k]});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dif_r[k] <= dif_nxt[k];
      nrm_r[k] <= nrm_k[k];
    end
  end

  // Hold the fetched center for the result
  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_fch_r) begin
      cen_hold_r <= cen_rd;
    end
  end

  // Stage 3: one multiplier per axis, squares on scan, normal products on fetch
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_b[k]   = s2_fch_r ? DIF_W'(nrm_r[k]) : dif_r[k];
      prd_nxt[k] = dif_r[k] * mul_b[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prd_r[k] <= prd_nxt[k];
    end
  end

  // Stage 4: sum the axes; one modular sum serves distance and dot product
  always_ff @(posedge clk) begin
    acc_r <= PRD_W'(prd_r[0]) + PRD_W'(prd_r[1]) + PRD_W'(prd_r[2]);
  end

  // Stage 5a: keep the first strictly nearest entry
  assign take_best = s4_vld_r && !s4_fch_r && (!best_have_r || (acc_r < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_have_r <= 1'b0;
    end else if (ctrl.query_start) begin
      best_have_r <= 1'b0;
    end else if (take_best) begin
      best_have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_idx_r  <= s4_idx_r;
      best_dist_r <= acc_r;
    end
  end

  // Stage 5b: magnitude, round half up to Q.16, saturate
  always_comb begin
    dot_mag  = acc_r[PRD_W-1] ? (~acc_r + 1'b1) : acc_r;
    dot_rnd  = dot_mag + PRD_W'(32768);
    alt_wide = dot_rnd[PRD_W-1:16];
    alt_sat  = (|alt_wide[RND_W-1:ALT_W]) ? '1 : alt_wide[ALT_W-1:0];
  end

  assign stat.scan_busy   = s1_vld_r || s2_vld_r || s3_vld_r || s4_vld_r;
  assign stat.result_done = s4_vld_r && s4_fch_r;

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= ctrl.emit_empty || stat.result_done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_empty) begin
      out_closest_index <= '0;
      out_altitude      <= '0;
      out_center_x      <= '0;
      out_center_y      <= '0;
      out_center_z      <= '0;
      out_empty_error   <= 1'b1;
    end else if (stat.result_done) begin
      out_closest_index <= IDX_W'(best_idx_r);
      out_altitude      <= alt_sat;
      out_center_x      <= cen_hold_r[3*POS_W-1:2*POS_W];
      out_center_y      <= cen_hold_r[2*POS_W-1:POS_W];
      out_center_z      <= cen_hold_r[POS_W-1:0];
      out_empty_error   <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cfa_checker.sv =====
// Port-level checker for closest_facet_altitude, attached by bind.
// Depends on cfa_pkg for field widths and the command codes.
`default_nettype none

module cfa_checker import cfa_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             in_command,
  input wire logic             out_strobe,
  input wire logic [IDX_W-1:0] out_closest_index,
  input wire logic [ALT_W-1:0] out_altitude,
  input wire logic             out_empty_error
);

  // An empty-table result carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_empty_error) |-> (out_closest_index == '0 && out_altitude == '0))
    else $error("empty result with nonzero fields");

  // A taken query either starts a scan or answers empty at once
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_QUERY) |=> (busy || (out_strobe && out_empty_error)))
    else $error("query beat neither scanned nor answered");

  // A load gives no result and leaves the block free
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_LOAD) |=> (!busy && !out_strobe))
    else $error("load beat produced a result or busy");

  // The end of a scan delivers its result beat
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> (out_strobe && !out_empty_error))
    else $error("scan ended without a result beat");

endmodule

bind closest_facet_altitude cfa_checker u_cfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_command        (in_command),
  .out_strobe        (out_strobe),
  .out_closest_index (out_closest_index),
  .out_altitude      (out_altitude),
  .out_empty_error   (out_empty_error)
);

`default_nettype wire

// ===== test/closest_facet_checker.sv =====
// Checker for the closest-facet altitude block: mirrors the facet tables,
// predicts each query result and compares it with the result port.
// Depends on cfa_pkg for field widths and command codes.
`timescale 1ns / 100ps

module closest_facet_checker import cfa_pkg::*; #(
  parameter int MAX_FACETS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    in_command,
  input  logic        [IDX_W-1:0] in_entry_index,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic signed [NRM_W-1:0] in_norm_x,
  input  logic signed [NRM_W-1:0] in_norm_y,
  input  logic signed [NRM_W-1:0] in_norm_z,
  input  logic                    out_strobe,
  input  logic        [IDX_W-1:0] out_closest_index,
  input  logic        [ALT_W-1:0] out_altitude,
  input  logic signed [POS_W-1:0] out_center_x,
  input  logic signed [POS_W-1:0] out_center_y,
  input  logic signed [POS_W-1:0] out_center_z,
  input  logic                    out_empty_error,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic        [CNT_W-1:0] cfg_data,
  output int                      mismatches,
  output int                      pending
);

  localparam logic [63:0] ALT_CEIL = (64'd1 << ALT_W) - 64'd1;

  typedef struct {
    logic        [IDX_W-1:0] index;
    logic        [ALT_W-1:0] alt;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    logic                    empty;
  } facet_hit_t;

  // Mirror of the facet tables and the count register
  logic signed [POS_W-1:0] centers [MAX_FACETS][3];
  logic signed [NRM_W-1:0] normals [MAX_FACETS][3];
  logic        [CNT_W-1:0] scan_count;
  facet_hit_t              nearest_due [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Print one line per wrong field and count it
  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("check: %s got %h want %h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  // Scan the first scan_count entries (at most MAX_FACETS) for the nearest center, first on ties,
  // then take the rounded, saturated normal distance to that facet's plane
  function automatic facet_hit_t nearest_facet(input logic signed [POS_W-1:0] px,
                                               input logic signed [POS_W-1:0] py,
                                               input logic signed [POS_W-1:0] pz);
    logic signed [POS_W-1:0] pt [3];
    facet_hit_t              hit;
    int unsigned             n;
    int unsigned             best;
    logic [65:0]             sq_sum;
    logic [65:0]             best_dist;
    longint                  diff;
    longint                  dot;
    longint unsigned         mag;
    longint unsigned         rounded;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    hit.index = '0;
    hit.alt   = '0;
    hit.cx    = '0;
    hit.cy    = '0;
    hit.cz    = '0;
    hit.empty = 1'b0;
    n = (scan_count > MAX_FACETS) ? MAX_FACETS : scan_count;
    if (n == 0) begin
      hit.empty = 1'b1;
      return hit;
    end
    best      = 0;
    best_dist = '0;
    for (int m = 0; m < n; m++) begin
      sq_sum = '0;
      for (int k = 0; k < 3; k++) begin
        diff   = longint'(pt[k]) - longint'(centers[m][k]);
        mag    = (diff < 0) ? -diff : diff;
        sq_sum = sq_sum + {2'b00, mag * mag};
      end
      if (m == 0 || sq_sum < best_dist) begin
        best      = m;
        best_dist = sq_sum;
      end
    end
    dot = 0;
    for (int k = 0; k < 3; k++) begin
      diff = longint'(pt[k]) - longint'(centers[best][k]);
      dot  = dot + diff * longint'(normals[best][k]);
    end
    mag     = (dot < 0) ? -dot : dot;
    rounded = (mag + 64'h8000) >> 16;
    if (rounded > ALT_CEIL) rounded = ALT_CEIL;
    hit.index = best[IDX_W-1:0];
    hit.alt   = rounded[ALT_W-1:0];
    hit.cx    = centers[best][0];
    hit.cy    = centers[best][1];
    hit.cz    = centers[best][2];
    return hit;
  endfunction

  // Track writes and beats, predict queries, compare each result beat
  always @(posedge clk) begin : watch
    facet_hit_t want;
    if (!rst_n) begin
      scan_count = '0;
      nearest_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) scan_count = cfg_data;
      if (start && !busy) begin
        if (in_command == CMD_LOAD) begin
          if (in_entry_index < MAX_FACETS) begin
            centers[in_entry_index][0] = in_pos_x;
            centers[in_entry_index][1] = in_pos_y;
            centers[in_entry_index][2] = in_pos_z;
            normals[in_entry_index][0] = in_norm_x;
            normals[in_entry_index][1] = in_norm_y;
            normals[in_entry_index][2] = in_norm_z;
          end
        end else begin
          nearest_due.push_back(nearest_facet(in_pos_x, in_pos_y, in_pos_z));
        end
      end
      if (out_strobe) begin
        if (nearest_due.size() == 0) begin
          flag_mismatch("unexpected result, index", 64'(out_closest_index), '0);
        end else begin
          want = nearest_due.pop_front();
          if (out_empty_error !== want.empty)
            flag_mismatch("empty_error", 64'(out_empty_error), 64'(want.empty));
          if (out_closest_index !== want.index)
            flag_mismatch("closest_index", 64'(out_closest_index), 64'(want.index));
          if (out_altitude !== want.alt)
            flag_mismatch("altitude", 64'(out_altitude), 64'(want.alt));
          if (out_center_x !== want.cx)
            flag_mismatch("center_x", 64'(out_center_x), 64'(want.cx));
          if (out_center_y !== want.cy)
            flag_mismatch("center_y", 64'(out_center_y), 64'(want.cy));
          if (out_center_z !== want.cz)
            flag_mismatch("center_z", 64'(out_center_z), 64'(want.cz));
        end
      end
    end
    pending <= nearest_due.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the closest-facet altitude testbench: clock, reset, stimulus and
// verdict. Depends on cfa_pkg, closest_facet_altitude and closest_facet_checker.
`timescale 1ns / 100ps

module testbench;
  import cfa_pkg::*;

  localparam int MAX_FACETS  = 1024;
  localparam int PERIOD      = 8;
  localparam int STALL_LIMIT = 8000;

  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [NRM_W-1:0] NRM_ONE      = 18'sh10000;
  localparam logic signed [NRM_W-1:0] NRM_NEG_ONE  = 18'sh30000;
  localparam logic signed [NRM_W-1:0] NRM_HALF     = 18'sh08000;
  localparam logic signed [NRM_W-1:0] NRM_SUB_HALF = 18'sh07FFF;
  localparam logic signed [NRM_W-1:0] NRM_FLOOR    = 18'sh20000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_command = CMD_LOAD;
  logic        [IDX_W-1:0] in_entry_index = '0;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic signed [POS_W-1:0] in_pos_z = '0;
  logic signed [NRM_W-1:0] in_norm_x = '0;
  logic signed [NRM_W-1:0] in_norm_y = '0;
  logic signed [NRM_W-1:0] in_norm_z = '0;
  logic                    out_strobe;
  logic        [IDX_W-1:0] out_closest_index;
  logic        [ALT_W-1:0] out_altitude;
  logic signed [POS_W-1:0] out_center_x;
  logic signed [POS_W-1:0] out_center_y;
  logic signed [POS_W-1:0] out_center_z;
  logic                    out_empty_error;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic        [CNT_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;

  // Stimulus bookkeeping: which entries hold data, and their centers
  bit                      written [MAX_FACETS];
  logic signed [POS_W-1:0] placed [MAX_FACETS][3];
  int unsigned             cur_count = 0;
  int                      sender_idle = 0;
  int                      n_loads = 0;
  int                      n_queries = 0;
  int                      n_empty = 0;
  int                      quiet_cycles = 0;

  always #(PERIOD / 2) clk = ~clk;

  closest_facet_altitude #(.MAX_FACETS(MAX_FACETS)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_entry_index    (in_entry_index),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_norm_x         (in_norm_x),
    .in_norm_y         (in_norm_y),
    .in_norm_z         (in_norm_z),
    .out_strobe        (out_strobe),
    .out_closest_index (out_closest_index),
    .out_altitude      (out_altitude),
    .out_center_x      (out_center_x),
    .out_center_y      (out_center_y),
    .out_center_z      (out_center_z),
    .out_empty_error   (out_empty_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  closest_facet_checker #(.MAX_FACETS(MAX_FACETS)) facet_watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_entry_index    (in_entry_index),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_norm_x         (in_norm_x),
    .in_norm_y         (in_norm_y),
    .in_norm_z         (in_norm_z),
    .out_strobe        (out_strobe),
    .out_closest_index (out_closest_index),
    .out_altitude      (out_altitude),
    .out_center_x      (out_center_x),
    .out_center_y      (out_center_y),
    .out_center_z      (out_center_z),
    .out_empty_error   (out_empty_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Coordinates: full range, a cluster near the origin, and the extremes
  function automatic logic signed [POS_W-1:0] pick_coord();
    int r;
    int t;
    r = $urandom_range(99);
    if (r < 25) return POS_W'($urandom);
    if (r < 75) begin
      t = int'($urandom_range(2097152)) - 1048576;
      return t;
    end
    case ($urandom_range(3))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Normals: mostly in range, some unit axes, some arbitrary patterns
  function automatic logic signed [NRM_W-1:0] pick_normal();
    int r;
    int t;
    r = $urandom_range(99);
    if (r < 70) begin
      t = int'($urandom_range(131072)) - 65536;
      return t[NRM_W-1:0];
    end
    if (r < 85) return $urandom_range(1) ? NRM_ONE : NRM_NEG_ONE;
    return NRM_W'($urandom);
  endfunction

  // Present one beat after a random gap and hold it until taken
  task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [POS_W-1:0] px, py, pz,
                           input logic signed [NRM_W-1:0] nx, ny, nz);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= idx;
    in_pos_x       <= px;
    in_pos_y       <= py;
    in_pos_z       <= pz;
    in_norm_x      <= nx;
    in_norm_y      <= ny;
    in_norm_z      <= nz;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_facet(input int unsigned idx, input logic signed [POS_W-1:0] px, py, pz,
                            input logic signed [NRM_W-1:0] nx, ny, nz);
    written[idx]   = 1'b1;
    placed[idx][0] = px;
    placed[idx][1] = py;
    placed[idx][2] = pz;
    n_loads++;
    send_beat(CMD_LOAD, idx[IDX_W-1:0], px, py, pz, nx, ny, nz);
  endtask

  // Query a point; index and normal fields carry noise the block must ignore
  task automatic ask_point(input logic signed [POS_W-1:0] px, py, pz);
    if (cur_count == 0) n_empty++;
    n_queries++;
    send_beat(CMD_QUERY, IDX_W'($urandom), px, py, pz,
              pick_normal(), pick_normal(), pick_normal());
  endtask

  // Drop start and hold off until every expected result has come
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_facet_count(input int unsigned v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_count = v;
  endtask

  // Query at a stored center, next to one, or anywhere
  task automatic query_random(input int unsigned span);
    int          r;
    int unsigned m;
    r = $urandom_range(99);
    if (span == 0 || r >= 55) begin
      ask_point(pick_coord(), pick_coord(), pick_coord());
    end else begin
      m = $urandom_range(span - 1);
      if (r < 15)
        ask_point(placed[m][0], placed[m][1], placed[m][2]);
      else
        ask_point(placed[m][0] + $urandom_range(8) - 4, placed[m][1] + $urandom_range(8) - 4,
                  placed[m][2] + $urandom_range(8) - 4);
    end
  endtask

  // Overwrite an entry, often inside the scanned range, sometimes duplicating a center
  task automatic load_random(input int unsigned span);
    int unsigned idx;
    int unsigned m;
    if ($urandom_range(99) < 70)
      idx = $urandom_range((span + 3 > MAX_FACETS - 1) ? MAX_FACETS - 1 : span + 3);
    else
      idx = $urandom_range(MAX_FACETS - 1);
    if (span != 0 && $urandom_range(99) < 20) begin
      m = $urandom_range(span - 1);
      load_facet(idx, placed[m][0], placed[m][1], placed[m][2],
                 pick_normal(), pick_normal(), pick_normal());
    end else begin
      load_facet(idx, pick_coord(), pick_coord(), pick_coord(),
                 pick_normal(), pick_normal(), pick_normal());
    end
  endtask

  initial begin
    int          ph;
    int          sent;
    int          r;
    int unsigned span;
    int unsigned e;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table after reset
    ask_point(pick_coord(), pick_coord(), pick_coord());
    // Extreme center with the most negative normal pattern, two equal centers,
    // and normals that sit just at and just under a half LSB of altitude
    load_facet(0, POS_MIN, POS_MIN, POS_MIN, NRM_FLOOR, NRM_FLOOR, NRM_FLOOR);
    load_facet(1, '0, '0, '0, NRM_HALF, '0, '0);
    load_facet(2, '0, '0, '0, NRM_ONE, NRM_ONE, NRM_NEG_ONE);
    load_facet(3, 32'sd2, '0, '0, NRM_SUB_HALF, '0, '0);
    // Saturated altitude from the far corner
    write_facet_count(1);
    ask_point(POS_MAX, POS_MAX, POS_MAX);
    // Ties keep the first entry; rounding half up and just below half
    write_facet_count(4);
    ask_point(32'sd1, '0, '0);
    ask_point(32'sd3, '0, '0);
    ask_point(32'shFFFB_0000, '0, '0);
    ask_point(POS_MIN, POS_MIN, POS_MIN);
    ask_point(POS_MAX, POS_MIN, '0);
    write_facet_count(0);
    ask_point(POS_MIN, POS_MAX, '1);

    // Random phases: no gaps, heavy gaps, none again, light gaps
    for (ph = 0; ph < 4; ph++) begin
      sender_idle = (ph == 1) ? 51 : (ph == 3) ? 16 : 0;
      sent = 0;
      while (sent < 128) begin
        r = $urandom_range(99);
        if (r < 8) span = 0;
        else if (r < 88) span = $urandom_range(24, 1);
        else span = $urandom_range(160, 25);
        // Every scanned entry must hold data before the scan range grows
        for (e = 0; e < span; e++) begin
          if (!written[e]) begin
            load_facet(e, pick_coord(), pick_coord(), pick_coord(),
                       pick_normal(), pick_normal(), pick_normal());
            sent++;
          end
        end
        write_facet_count(span);
        repeat ($urandom_range(32, 16)) begin
          if ($urandom_range(99) < 55) query_random(span);
          else load_random(span);
          sent++;
        end
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("tb: ran %0d facet loads and %0d point queries, %0d against an empty table,",
             n_loads, n_queries, n_empty);
    $display("tb: facet counts from 0 up to 160 with sender gaps of 0, 16 and 51 percent");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
